FILE: design/tccw_pkg.sv
// Shared types and constants of the text console character writer.
package tccw_pkg;

	localparam int POS_W = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int NIB_W = 4;
	localparam int TAB_W = 5;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h83;
	localparam logic [NIB_W-1:0] NIBBLE_MASK = 4'hf;

	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [CHAR_W-1:0] CH_A_LOWER = 8'h61;
	localparam logic [CHAR_W-1:0] CH_C_LOWER = 8'h63;
	localparam logic [CHAR_W-1:0] CH_I_LOWER = 8'h69;
	localparam logic [CHAR_W-1:0] CH_R_LOWER = 8'h72;

	localparam logic REG_TAB_WIDTH = 1'b0;
	localparam logic REG_SPILL_ENABLE = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SLASH,
		PH_BG,
		PH_FG
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TAB_MOD,
		BK_COL_QUO,
		BK_COL_MOD
	} back_state_t;

	typedef enum logic {
		CMD_CHAR,
		CMD_SET
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] attr;
		logic [POS_W-1:0] pos;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic [TAB_W-1:0] tab_width;
		logic spill_enable;
	} cfg_t;

endpackage

FILE: design/tccw_front.sv
// Front end: escape decoding, attribute tracking, command generation.
module tccw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [7:0]            char_code,
	input  logic                  end_of_message,
	input  logic [10:0]           position,
	input  logic                  q_full,
	output logic                  q_push,
	output tccw_pkg::cmd_t        q_cmd
);
	import tccw_pkg::*;

	phase_t phase_q, phase_d;
	logic [ATTR_W-1:0] cur_attr_q, cur_attr_d;
	logic [ATTR_W-1:0] saved_attr_q, saved_attr_d;
	logic [NIB_W-1:0] pend_bg_q, pend_bg_d;
	logic pend_q;
	cmd_t pend_cmd_q;

	logic accept;
	cmd_t cmd0, cmd1;
	logic [1:0] n_cmd;
	logic [NIB_W-1:0] nib;

	function automatic logic [NIB_W-1:0] hex_nibble(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] t;
		if (c > CH_NINE)
			t = c - CH_A_LOWER + 8'd10;
		else
			t = c - CH_ZERO;
		return t[NIB_W-1:0];
	endfunction

	assign in_ready = !pend_q && !q_full;
	assign accept = in_valid && in_ready;
	assign nib = hex_nibble(char_code);

	// next state of escape decoder and attributes
	always_comb begin
		phase_d = phase_q;
		cur_attr_d = cur_attr_q;
		saved_attr_d = saved_attr_q;
		pend_bg_d = pend_bg_q;
		if (op) begin
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_SLASH: begin
					phase_d = PH_IDLE;
					if (char_code == CH_C_LOWER) begin
						if (!end_of_message)
							phase_d = PH_BG;
					end else if (char_code == CH_R_LOWER) begin
						cur_attr_d = saved_attr_q;
					end else if (char_code == CH_I_LOWER) begin
						cur_attr_d = {cur_attr_q[NIB_W-1:0], cur_attr_q[ATTR_W-1:NIB_W]};
					end else if (char_code == CH_BSLASH && !end_of_message) begin
						phase_d = PH_SLASH;
					end
				end
				PH_BG: begin
					if (end_of_message) begin
						phase_d = PH_IDLE;
					end else begin
						pend_bg_d = (char_code == CH_UNDERSCORE) ?
							cur_attr_q[ATTR_W-1:NIB_W] : nib;
						phase_d = PH_FG;
					end
				end
				PH_FG: begin
					saved_attr_d = cur_attr_q;
					cur_attr_d = {pend_bg_q & NIBBLE_MASK,
						(char_code == CH_UNDERSCORE) ? cur_attr_q[NIB_W-1:0] : nib};
					phase_d = PH_IDLE;
				end
				PH_IDLE: begin
					if (char_code == CH_BSLASH && !end_of_message)
						phase_d = PH_SLASH;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// commands caused by the item
	always_comb begin
		cmd0 = '{kind: CMD_CHAR, ch: char_code, attr: cur_attr_q, pos: position, last: 1'b1};
		cmd1 = cmd0;
		n_cmd = 2'd0;
		if (op) begin
			cmd0.kind = CMD_SET;
			n_cmd = 2'd1;
		end else begin
			unique case (phase_q)
				PH_SLASH: begin
					if (char_code != CH_C_LOWER && char_code != CH_R_LOWER &&
					    char_code != CH_I_LOWER) begin
						cmd0.ch = CH_BSLASH;
						if (char_code == CH_BSLASH && !end_of_message) begin
							n_cmd = 2'd1;
						end else begin
							cmd0.last = 1'b0;
							n_cmd = 2'd2;
						end
					end
				end
				PH_BG, PH_FG: n_cmd = 2'd0;
				PH_IDLE: begin
					if (!(char_code == CH_BSLASH && !end_of_message))
						n_cmd = 2'd1;
				end
				default: n_cmd = 2'd0;
			endcase
		end
	end

	always_comb begin
		if (pend_q) begin
			q_push = !q_full;
			q_cmd = pend_cmd_q;
		end else begin
			q_push = accept && (n_cmd != 2'd0);
			q_cmd = cmd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_attr_q <= ATTR_RESET;
			saved_attr_q <= '0;
			pend_bg_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				cur_attr_q <= cur_attr_d;
				saved_attr_q <= saved_attr_d;
				pend_bg_q <= pend_bg_d;
			end
			if (pend_q && !q_full)
				pend_q <= 1'b0;
			else if (accept && n_cmd == 2'd2)
				pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && n_cmd == 2'd2)
			pend_cmd_q <= cmd1;
	end

endmodule

FILE: design/tccw_queue.sv
// Command queue between front end and back end.
module tccw_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tccw_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output tccw_pkg::cmd_t        head,
	output logic                  full,
	output logic                  empty
);
	import tccw_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

FILE: design/tccw_div.sv
// Serial restoring remainder unit, one dividend bit per cycle.
module tccw_div #(
	parameter int DVD_W = 11,
	parameter int DVS_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVS_W-1:0] remainder
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;

	assign busy = busy_q;
	assign remainder = rem_q;
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q})
				rem_q <= diff[DVS_W-1:0];
			else
				rem_q <= trial[DVS_W-1:0];
		end
	end

endmodule

FILE: design/tccw_back.sv
// Back end: cursor, column tracking, cell writes and result register.
module tccw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tccw_pkg::cfg_t        cfg,
	input  tccw_pkg::cmd_t        head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  write_valid,
	output logic [10:0]           cell_index,
	output logic [7:0]            glyph,
	output logic [7:0]            cell_attribute,
	output logic [10:0]           cursor_position,
	output logic                  spill,
	output logic                  last
);
	import tccw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CELL_BITS = $clog2(CELLS + 1);
	localparam int CUR_W = (CELL_BITS > POS_W) ? CELL_BITS : POS_W;
	localparam int SUM_W = CUR_W + 1;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int C_BITS = $clog2(COLUMNS + 1);
	localparam logic [SUM_W-1:0] CELLS_S = SUM_W'(CELLS);
	// reciprocal of COLUMNS, exact for every cursor value
	localparam int REC_S = CUR_W + C_BITS;
	localparam int REC_W = CUR_W + 2;
	localparam int PROD_W = REC_S + CUR_W;
	localparam logic [REC_W-1:0] REC_M = REC_W'(((1 << REC_S) + COLUMNS - 1) / COLUMNS);

	back_state_t state_q, state_d;
	logic [CUR_W-1:0] cursor_q, cursor_d;
	logic [COL_W-1:0] col_q, col_d;
	logic tab_spill_q, tab_last_q;
	logic [CUR_W-1:0] quo_q;

	logic out_valid_q;
	logic wv_q, spill_q, last_q;
	logic [POS_W-1:0] idx_q, curpos_q;
	logic [CHAR_W-1:0] glyph_q;
	logic [ATTR_W-1:0] attr_q;

	logic out_free, take;
	logic emit, e_wv, e_spill, e_last;
	logic [POS_W-1:0] e_idx;
	logic [CHAR_W-1:0] e_glyph;
	logic [ATTR_W-1:0] e_attr;
	logic keep_tab;

	logic div_start, div_busy;
	logic [TAB_W-1:0] div_rem;

	logic [SUM_W-1:0] cur_s, col_s, pos_s, nl_sum, tab_sum;
	logic [TAB_W-1:0] tw_eff;
	logic sp_any, sp_nl;
	logic [PROD_W-1:0] col_prod;
	logic [CUR_W-1:0] col_rem;

	assign out_free = !out_valid_q || out_ready;
	assign take = (state_q == BK_IDLE) && !q_empty && out_free;
	assign q_pop = take;

	assign tw_eff = (cfg.tab_width == '0) ? TAB_W'(1) : cfg.tab_width;
	assign cur_s = SUM_W'(cursor_q);
	assign col_s = SUM_W'(col_q);
	assign pos_s = SUM_W'(head.pos);
	assign nl_sum = cur_s + SUM_W'(COLUMNS) - col_s;
	assign tab_sum = cur_s + SUM_W'(tw_eff) - SUM_W'(div_rem);
	assign sp_any = cfg.spill_enable && (cur_s + 1'b1 >= CELLS_S);
	assign sp_nl = cfg.spill_enable && (cur_s >= CELLS_S - SUM_W'(COLUMNS));
	assign col_prod = PROD_W'(cursor_q) * PROD_W'(REC_M);
	assign col_rem = cursor_q - quo_q * CUR_W'(COLUMNS);

	tccw_div #(
		.DVD_W(COL_W),
		.DVS_W(TAB_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(col_q),
		.divisor(tw_eff),
		.busy(div_busy),
		.remainder(div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (take && head.kind == CMD_SET)
					state_d = BK_COL_QUO;
				else if (take && head.ch == CH_TAB)
					state_d = BK_TAB_MOD;
			end
			BK_TAB_MOD: begin
				if (!div_busy && out_free)
					state_d = BK_COL_QUO;
			end
			BK_COL_QUO: state_d = BK_COL_MOD;
			BK_COL_MOD: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath and result generation
	always_comb begin
		cursor_d = cursor_q;
		col_d = col_q;
		emit = 1'b0;
		e_wv = 1'b0;
		e_idx = '0;
		e_glyph = '0;
		e_attr = '0;
		e_spill = 1'b0;
		e_last = head.last;
		keep_tab = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (take) begin
					if (head.kind == CMD_SET) begin
						cursor_d = (pos_s > CELLS_S) ? CUR_W'(CELLS) : CUR_W'(head.pos);
						emit = 1'b1;
					end else if (head.ch == CH_NEWLINE) begin
						cursor_d = (nl_sum > CELLS_S) ? CUR_W'(CELLS) : nl_sum[CUR_W-1:0];
						col_d = '0;
						emit = 1'b1;
						e_spill = sp_any || sp_nl;
					end else if (head.ch == CH_TAB) begin
						keep_tab = 1'b1;
						div_start = 1'b1;
					end else begin
						emit = 1'b1;
						e_spill = sp_any;
						if (cur_s < CELLS_S) begin
							e_wv = 1'b1;
							e_idx = cursor_q[POS_W-1:0];
							e_glyph = head.ch;
							e_attr = head.attr;
							cursor_d = cursor_q + 1'b1;
							col_d = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
						end
					end
				end
			end
			BK_TAB_MOD: begin
				if (!div_busy && out_free) begin
					cursor_d = (tab_sum > CELLS_S) ? CUR_W'(CELLS) : tab_sum[CUR_W-1:0];
					emit = 1'b1;
					e_spill = tab_spill_q;
					e_last = tab_last_q;
				end
			end
			BK_COL_MOD: col_d = col_rem[COL_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cursor_q <= '0;
			col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cursor_q <= cursor_d;
			col_q <= col_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keep_tab) begin
			tab_spill_q <= sp_any;
			tab_last_q <= head.last;
		end
		if (state_q == BK_COL_QUO)
			quo_q <= col_prod[REC_S +: CUR_W];
		if (emit) begin
			wv_q <= e_wv;
			idx_q <= e_idx;
			glyph_q <= e_glyph;
			attr_q <= e_attr;
			curpos_q <= cursor_d[POS_W-1:0];
			spill_q <= e_spill;
			last_q <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign write_valid = wv_q;
	assign cell_index = idx_q;
	assign glyph = glyph_q;
	assign cell_attribute = attr_q;
	assign cursor_position = curpos_q;
	assign spill = spill_q;
	assign last = last_q;

endmodule

FILE: design/text_console_char_writer.sv
// Top level of the text console character writer: register port, front, queue, back.
// A plain character or newline passes through a queue entry and then the result register.
// One result per cycle while the back is idle and out_ready is high; a two-result item holds in_ready low.
// A tab holds the back in BK_TAB_MOD for the serial tab-stop remainder over the W-bit column
// index (W = 7 by default), then BK_COL_QUO, BK_COL_MOD; a set-cursor item holds it in both.
// Reset: asynchronous, control state to its reset values at once, no clearing pass; data registers are not reset.
module text_console_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  char_code,
	input  logic        end_of_message,
	input  logic [10:0] position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [10:0] cell_index,
	output logic [7:0]  glyph,
	output logic [7:0]  cell_attribute,
	output logic [10:0] cursor_position,
	output logic        spill,
	output logic        last
);
	import tccw_pkg::*;

	cfg_t cfg_q;
	logic reg_sel;
	logic q_full, q_empty, q_push, q_pop;
	cmd_t q_cmd, q_head;

	assign pready = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tab_width <= TAB_W'(4);
			cfg_q.spill_enable <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_TAB_WIDTH: cfg_q.tab_width <= pwdata[TAB_W-1:0];
				REG_SPILL_ENABLE: cfg_q.spill_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TAB_WIDTH: prdata = {{(32-TAB_W){1'b0}}, cfg_q.tab_width};
			REG_SPILL_ENABLE: prdata = {31'b0, cfg_q.spill_enable};
			default: prdata = '0;
		endcase
	end

	tccw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.char_code(char_code),
		.end_of_message(end_of_message),
		.position(position),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	tccw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.pop(q_pop),
		.head(q_head),
		.full(q_full),
		.empty(q_empty)
	);

	tccw_back #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(q_head),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.write_valid(write_valid),
		.cell_index(cell_index),
		.glyph(glyph),
		.cell_attribute(cell_attribute),
		.cursor_position(cursor_position),
		.spill(spill),
		.last(last)
	);

endmodule
